// ===== sv/twm_pkg.sv =====
package twm_pkg;

  localparam int unsigned MaxLenDefault = 128;
  localparam int unsigned ChW = 8;

  localparam logic [ChW-1:0] ChHash   = 8'h23;
  localparam logic [ChW-1:0] ChPlus   = 8'h2B;
  localparam logic [ChW-1:0] ChDollar = 8'h24;
  localparam logic [ChW-1:0] ChSlash  = 8'h2F;

  typedef enum logic [1:0] {
    TS_LOAD,
    TS_WALK,
    TS_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_RD,
    WK_EV
  } walk_state_e;

  typedef enum logic [2:0] {
    MD_EXACT,
    MD_HEAD,
    MD_SKIP,
    MD_PLUS,
    MD_CMP
  } walk_mode_e;

  // Walker start request.
  typedef struct packed {
    logic start;
    logic wild_a;
    logic wild_b;
  } twm_req_t;

  // Walker completion.
  typedef struct packed {
    logic done;
    logic match;
  } twm_res_t;

endpackage

// ===== sv/topic_wildcard_matcher.sv =====
// Character transactions are taken one per cycle while loading. The final character
// of the second topic starts a compare walk through both text memories, unless a topic
// overflowed; each character step is a registered memory read, then an evaluate. Input
// is held off until the result is loaded into the output register.
// Reset (asynchronous, active low) clears lengths, flags and control; text memories
// are not cleared, only characters below the current length are ever used.
module topic_wildcard_matcher #(
  parameter int unsigned MAX_LEN = twm_pkg::MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // ch[7:0]
  input  logic       s_axis_tuser,   // op
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // match[0], overflow[1], zeros above
);

  localparam int unsigned Lw = $clog2(MAX_LEN);
  localparam logic [Lw-1:0] LenCap = Lw'(MAX_LEN - 1);

  twm_pkg::top_state_e state_q, state_d;
  logic [Lw-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic done_a_q, done_a_d, done_b_q, done_b_d;
  logic wild_a_q, wild_a_d, wild_b_q, wild_b_d;
  logic too_long_q, too_long_d;
  logic res_match_q, res_match_d, res_ovf_q, res_ovf_d;
  logic out_valid_q, out_valid_d, out_match_q, out_match_d, out_ovf_q, out_ovf_d;

  logic          accept, is_wild, store;
  logic [Lw-1:0] elen;
  logic [Lw-1:0] addr_a, addr_b;
  logic [7:0]    data_a, data_b;
  twm_pkg::twm_req_t req;
  twm_pkg::twm_res_t res;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_wild = (s_axis_tdata == twm_pkg::ChPlus) || (s_axis_tdata == twm_pkg::ChHash);
  assign elen    = s_axis_tuser ? (done_b_q ? '0 : len_b_q) : (done_a_q ? '0 : len_a_q);
  assign store   = accept && (elen < LenCap);

  twm_ram #(.Width(twm_pkg::ChW), .Depth(MAX_LEN)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (store && !s_axis_tuser),
    .waddr_i (elen),
    .wdata_i (s_axis_tdata),
    .raddr_i (addr_a),
    .rdata_o (data_a)
  );

  twm_ram #(.Width(twm_pkg::ChW), .Depth(MAX_LEN)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (store && s_axis_tuser),
    .waddr_i (elen),
    .wdata_i (s_axis_tdata),
    .raddr_i (addr_b),
    .rdata_o (data_b)
  );

  twm_walk #(.MaxLen(MAX_LEN)) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .len_a_i  (len_a_q),
    .len_b_i  (len_b_q),
    .data_a_i (data_a),
    .data_b_i (data_b),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twm_pkg::TS_LOAD;
      len_a_q     <= '0;
      len_b_q     <= '0;
      done_a_q    <= 1'b1;
      done_b_q    <= 1'b1;
      wild_a_q    <= 1'b0;
      wild_b_q    <= 1'b0;
      too_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      done_a_q    <= done_a_d;
      done_b_q    <= done_b_d;
      wild_a_q    <= wild_a_d;
      wild_b_q    <= wild_b_d;
      too_long_q  <= too_long_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_match_q <= res_match_d;
    res_ovf_q   <= res_ovf_d;
    out_match_q <= out_match_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    done_a_d    = done_a_q;
    done_b_d    = done_b_q;
    wild_a_d    = wild_a_q;
    wild_b_d    = wild_b_q;
    too_long_d  = too_long_q;
    res_match_d = res_match_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_match_d = out_match_q;
    out_ovf_d   = out_ovf_q;
    req         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      twm_pkg::TS_LOAD: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (s_axis_tuser) begin
            len_b_d  = store ? elen + 1'b1 : elen;
            wild_b_d = (done_b_q ? 1'b0 : wild_b_q) || (store && is_wild);
            done_b_d = s_axis_tlast;
          end else begin
            len_a_d  = store ? elen + 1'b1 : elen;
            wild_a_d = (done_a_q ? 1'b0 : wild_a_q) || (store && is_wild);
            done_a_d = s_axis_tlast;
          end
          if (!store) too_long_d = 1'b1;
          if (s_axis_tuser && s_axis_tlast) begin
            too_long_d = 1'b0;
            if (too_long_q || !store) begin
              res_match_d = 1'b0;
              res_ovf_d   = 1'b1;
              state_d     = twm_pkg::TS_OUT;
            end else begin
              state_d = twm_pkg::TS_WALK;
            end
          end
        end
      end
      twm_pkg::TS_WALK: begin
        req.start  = 1'b1;
        req.wild_a = wild_a_q;
        req.wild_b = wild_b_q;
        if (res.done) begin
          res_match_d = res.match;
          res_ovf_d   = 1'b0;
          state_d     = twm_pkg::TS_OUT;
        end
      end
      twm_pkg::TS_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_match_d = res_match_q;
          out_ovf_d   = res_ovf_q;
          state_d     = twm_pkg::TS_LOAD;
        end
      end
      default: begin
        state_d = twm_pkg::TS_LOAD;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_match_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("overflow result reports a match");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != twm_pkg::TS_LOAD |-> !s_axis_tready)
    else $error("input taken during compare");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LenCap) && (len_b_q <= LenCap))
    else $error("topic length beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser && s_axis_tlast |=> !too_long_q)
    else $error("overflow flag not cleared after result");

endmodule

// ===== sv/twm_ram.sv =====
module twm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/twm_walk.sv =====
module twm_walk #(
  parameter int unsigned MaxLen = twm_pkg::MaxLenDefault,
  localparam int unsigned Lw = $clog2(MaxLen)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  twm_pkg::twm_req_t            req_i,
  input  logic [Lw-1:0]                len_a_i,
  input  logic [Lw-1:0]                len_b_i,
  input  logic [twm_pkg::ChW-1:0]      data_a_i,
  input  logic [twm_pkg::ChW-1:0]      data_b_i,
  output logic [Lw-1:0]                addr_a_o,
  output logic [Lw-1:0]                addr_b_o,
  output twm_pkg::twm_res_t            res_o
);

  twm_pkg::walk_state_e state_q, state_d;
  twm_pkg::walk_mode_e  mode_q, mode_d;
  logic [Lw-1:0] pa_q, pa_d, pb_q, pb_d;

  logic ea, eb, sa, sb, hash_a, hash_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twm_pkg::WK_IDLE;
      mode_q  <= twm_pkg::MD_EXACT;
      pa_q    <= '0;
      pb_q    <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
    end
  end

  assign addr_a_o = pa_q;
  assign addr_b_o = pb_q;

  // A side that has run off its end reads as an end marker, never as a character.
  assign ea = (pa_q >= len_a_i);
  assign eb = (pb_q >= len_b_i);
  assign sa = !ea && (data_a_i == twm_pkg::ChSlash);
  assign sb = !eb && (data_b_i == twm_pkg::ChSlash);
  assign hash_a = !ea && (data_a_i == twm_pkg::ChHash);
  assign hash_b = !eb && (data_b_i == twm_pkg::ChHash);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    res_o     = '0;
    case (state_q)
      twm_pkg::WK_IDLE: begin
        if (req_i.start) begin
          pa_d = '0;
          pb_d = '0;
          if (req_i.wild_a && req_i.wild_b) begin
            res_o.done = 1'b1;
          end else if (!req_i.wild_a && !req_i.wild_b) begin
            if (len_a_i != len_b_i) begin
              res_o.done = 1'b1;
            end else begin
              mode_d  = twm_pkg::MD_EXACT;
              state_d = twm_pkg::WK_RD;
            end
          end else begin
            mode_d  = twm_pkg::MD_HEAD;
            state_d = twm_pkg::WK_RD;
          end
        end
      end
      twm_pkg::WK_RD: begin
        state_d = twm_pkg::WK_EV;
      end
      twm_pkg::WK_EV: begin
        state_d = twm_pkg::WK_RD;
        case (mode_q)
          twm_pkg::MD_EXACT: begin
            if (ea || eb) begin
              res_o.done  = 1'b1;
              res_o.match = ea && eb;
              state_d     = twm_pkg::WK_IDLE;
            end else if (data_a_i != data_b_i) begin
              res_o.done = 1'b1;
              state_d    = twm_pkg::WK_IDLE;
            end else begin
              pa_d = pa_q + 1'b1;
              pb_d = pb_q + 1'b1;
            end
          end
          twm_pkg::MD_HEAD: begin
            if (hash_a || hash_b) begin
              res_o.done  = 1'b1;
              res_o.match = !((!ea && data_a_i == twm_pkg::ChDollar) ||
                              (!eb && data_b_i == twm_pkg::ChDollar));
              state_d     = twm_pkg::WK_IDLE;
            end else begin
              mode_d  = twm_pkg::MD_SKIP;
              state_d = twm_pkg::WK_EV;
            end
          end
          twm_pkg::MD_SKIP: begin
            if (sa || sb) begin
              if (sa) pa_d = pa_q + 1'b1;
              if (sb) pb_d = pb_q + 1'b1;
            end else if (!ea && !eb && !hash_a && !hash_b) begin
              if (data_a_i == twm_pkg::ChPlus || data_b_i == twm_pkg::ChPlus) begin
                mode_d = twm_pkg::MD_PLUS;
              end else begin
                mode_d = twm_pkg::MD_CMP;
              end
              state_d = twm_pkg::WK_EV;
            end else begin
              res_o.done  = 1'b1;
              res_o.match = hash_a || hash_b || (ea && eb);
              state_d     = twm_pkg::WK_IDLE;
            end
          end
          twm_pkg::MD_PLUS: begin
            if (!ea && !sa) pa_d = pa_q + 1'b1;
            if (!eb && !sb) pb_d = pb_q + 1'b1;
            if ((ea || sa) && (eb || sb)) begin
              mode_d  = twm_pkg::MD_SKIP;
              state_d = twm_pkg::WK_EV;
            end
          end
          twm_pkg::MD_CMP: begin
            if ((ea || sa) && (eb || sb)) begin
              mode_d  = twm_pkg::MD_SKIP;
              state_d = twm_pkg::WK_EV;
            end else if ((ea || sa) || (eb || sb) || (data_a_i != data_b_i)) begin
              res_o.done = 1'b1;
              state_d    = twm_pkg::WK_IDLE;
            end else begin
              pa_d = pa_q + 1'b1;
              pb_d = pb_q + 1'b1;
            end
          end
          default: begin
            res_o.done = 1'b1;
            state_d    = twm_pkg::WK_IDLE;
          end
        endcase
      end
      default: begin
        state_d = twm_pkg::WK_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.match |-> res_o.done)
    else $error("match without done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == twm_pkg::WK_RD |=> state_q == twm_pkg::WK_EV)
    else $error("read not followed by evaluate");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != twm_pkg::WK_IDLE |-> (pa_q <= len_a_i) && (pb_q <= len_b_i))
    else $error("walk pointer past topic end");

endmodule

// ===== tb/tb_topic_wildcard_matcher.sv =====
module tb_topic_wildcard_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLen = twm_pkg::MaxLenDefault;
  localparam logic OpFirst  = 1'b0;
  localparam logic OpSecond = 1'b1;

  typedef struct packed {
    logic match;
    logic overflow;
  } verdict_t;

  // Tracks both topics as the block stores them and keeps the verdicts still owed.
  class topic_scoreboard;
    logic [7:0] text_a[MaxLen];
    logic [7:0] text_b[MaxLen];
    int unsigned len_a, len_b;
    bit done_a, done_b, wild_a, wild_b, too_long;
    verdict_t pending[$];
    int errors;

    function new();
      len_a = 0;
      len_b = 0;
      done_a = 1;
      done_b = 1;
      wild_a = 0;
      wild_b = 0;
      too_long = 0;
      errors = 0;
    endfunction

    function bit is_wild(logic [7:0] c);
      return c == twm_pkg::ChPlus || c == twm_pkg::ChHash;
    endfunction

    function bit next_level(bit side, ref int unsigned pos, ref int unsigned st,
                            ref int unsigned n);
      int unsigned p;
      int unsigned len;
      p = pos;
      len = side ? len_b : len_a;
      while (p < len && (side ? text_b[p] : text_a[p]) == twm_pkg::ChSlash) p++;
      if (p >= len) begin
        pos = p;
        return 0;
      end
      st = p;
      while (p < len && (side ? text_b[p] : text_a[p]) != twm_pkg::ChSlash) p++;
      n = p - st;
      pos = p;
      return 1;
    endfunction

    function bit same_level(int unsigned sa, int unsigned sb, int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (text_a[sa+i] != text_b[sb+i]) return 0;
      return 1;
    endfunction

    function bit topics_match();
      int unsigned pa, pb, sa, sb, na, nb;
      bit ha, hb, lvl_ok;
      pa = 0; pb = 0; sa = 0; sb = 0; na = 0; nb = 0;
      if (wild_a && wild_b) return 0;
      if (!wild_a && !wild_b)
        return len_a == len_b && same_level(0, 0, len_a);
      if ((len_a > 0 && text_a[0] == twm_pkg::ChHash) ||
          (len_b > 0 && text_b[0] == twm_pkg::ChHash)) begin
        if ((len_a > 0 && text_a[0] == twm_pkg::ChDollar) ||
            (len_b > 0 && text_b[0] == twm_pkg::ChDollar)) return 0;
        return 1;
      end
      ha = next_level(0, pa, sa, na);
      hb = next_level(1, pb, sb, nb);
      while (ha && hb && text_a[sa] != twm_pkg::ChHash && text_b[sb] != twm_pkg::ChHash) begin
        lvl_ok = na == nb && same_level(sa, sb, na);
        if (!lvl_ok && text_a[sa] != twm_pkg::ChPlus && text_b[sb] != twm_pkg::ChPlus)
          return 0;
        ha = next_level(0, pa, sa, na);
        hb = next_level(1, pb, sb, nb);
      end
      if ((ha && text_a[sa] == twm_pkg::ChHash) || (hb && text_b[sb] == twm_pkg::ChHash))
        return 1;
      return !ha && !hb;
    endfunction

    function void note_char(logic op, logic [7:0] c, logic last);
      verdict_t v;
      if (op == OpFirst) begin
        if (done_a) begin len_a = 0; wild_a = 0; done_a = 0; end
        if (len_a < MaxLen - 1) begin
          text_a[len_a] = c;
          len_a++;
          if (is_wild(c)) wild_a = 1;
        end else too_long = 1;
        if (last) done_a = 1;
      end else begin
        if (done_b) begin len_b = 0; wild_b = 0; done_b = 0; end
        if (len_b < MaxLen - 1) begin
          text_b[len_b] = c;
          len_b++;
          if (is_wild(c)) wild_b = 1;
        end else too_long = 1;
        if (last) begin
          done_b = 1;
          v.overflow = too_long;
          v.match = too_long ? 1'b0 : topics_match();
          pending.push_back(v);
          too_long = 0;
        end
      end
    endfunction

    function void check_verdict(logic [7:0] data);
      verdict_t v;
      if (pending.size() == 0) begin
        report_mismatch("verdict with none pending");
        return;
      end
      v = pending.pop_front();
      if (data[0] !== v.match) report_mismatch("match bit");
      if (data[1] !== v.overflow) report_mismatch("overflow bit");
      if (data[7:2] !== 6'd0) report_mismatch("padding bits");
    endfunction

    function void report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [7:0] m_axis_tdata;

  topic_wildcard_matcher dut (.*);

  topic_scoreboard sb = new();
  bit sender_idles = 1;
  bit receiver_idles = 1;
  bit hold_off = 0;
  int unsigned rx_idle = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one character transaction, possibly after a random idle burst.
  task automatic send_char(logic op, logic [7:0] c, logic last);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(op, c, last);
    @(negedge clk_i);
  endtask

  task automatic send_topic(logic op, string s);
    for (int i = 0; i < s.len(); i++) send_char(op, s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return twm_pkg::ChSlash;
      2: return twm_pkg::ChPlus;
      3: return twm_pkg::ChHash;
      4: return twm_pkg::ChDollar;
      5: return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(8'h61, 8'h63));
    endcase
  endfunction

  // Random topic built from short levels so that many pairs actually match.
  task automatic send_random_topic(logic op, int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_char(op, pick_char(), i == len - 1);
  endtask

  // The receiver idles in random bursts.
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else if (rx_idle != 0) begin
      m_axis_tready <= 0;
      rx_idle--;
    end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 0;
      rx_idle = $urandom_range(0, 15);
    end else m_axis_tready <= 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned drain;
    bit held;
    s_axis_tvalid = 0;
    s_axis_tuser = 0;
    s_axis_tdata = 8'h61;
    s_axis_tlast = 0;
    m_axis_tready = 0;
    held = 0;
    rst_ni = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Compare against an empty first topic right after reset.
    send_topic(OpSecond, "a");
    send_topic(OpFirst, "a/b/c");
    send_topic(OpSecond, "a/b/c");
    send_topic(OpSecond, "a/+/c");
    send_topic(OpFirst, "#");
    send_topic(OpSecond, "$x");
    send_topic(OpFirst, "a//+");
    send_topic(OpSecond, "a/b/c");
    send_char(OpFirst, 8'h01, 0);
    send_char(OpFirst, 8'hFF, 1);
    send_char(OpSecond, 8'h01, 0);
    send_char(OpSecond, 8'hFF, 1);

    // Long topics: one at the limit and one past it.
    for (int unsigned i = 0; i < MaxLen - 1; i++) send_char(OpFirst, "x", i == MaxLen - 2);
    send_random_topic(OpSecond, 3);
    for (int unsigned i = 0; i < MaxLen + 2; i++) send_char(OpFirst, "y", i == MaxLen + 1);
    send_random_topic(OpSecond, 2);

    sent = 0;
    while (sent < 700) begin
      int unsigned la;
      int unsigned lb;
      if (sent > 550) begin
        sender_idles = 0;
        receiver_idles = 0;
      end
      if (sent >= 200 && !held) begin
        held = 1;
        fork
          begin
            hold_off = 1;
            repeat (600) @(negedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      la = $urandom_range(1, 10);
      lb = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        send_random_topic(OpFirst, la);
        sent += la;
      end
      send_random_topic(OpSecond, lb);
      sent += lb;
    end
    s_axis_tvalid <= 0;

    drain = 0;
    while (sb.pending.size() != 0 && drain < 100000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (4 * MaxLen + 20) @(negedge clk_i);
    if (sb.pending.size() != 0) sb.report_mismatch("verdicts never arrived");
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
